// File: hdl/u8u16_pkg.sv
// u8u16_pkg: shared types, constants and the lead-byte classifier for the
// UTF-8 to UTF-16 transcoder. No dependencies.
package u8u16_pkg;

    // One decoded byte's worth of work: a run of '?' units, then 0..2 units.
    typedef struct packed {
        logic [1:0]  reps;
        logic [1:0]  tail;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } t_cmd;

    // Byte classes, keyed on the top five bits
    localparam logic [2:0] CLS_CONT  = 3'd0;
    localparam logic [2:0] CLS_ASCII = 3'd1;
    localparam logic [2:0] CLS_LEAD2 = 3'd2;
    localparam logic [2:0] CLS_LEAD3 = 3'd3;
    localparam logic [2:0] CLS_LEAD4 = 3'd4;
    localparam logic [2:0] CLS_BAD   = 3'd5;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'h003F;
    // 0xD800 - (0x10000 >> 10): high surrogate straight from cp >> 10
    localparam logic [15:0] HIGH_SURR_OFFSET = 16'hD7C0;
    // top six bits of 0xDC00
    localparam logic [5:0]  LOW_SURR_TAG     = 6'b110111;

    function automatic logic [2:0] lead_class(input logic [4:0] top5);
        logic [2:0] cls;
        unique case (top5) inside
            [5'd0:5'd15]:  cls = CLS_ASCII;
            [5'd16:5'd23]: cls = CLS_CONT;
            [5'd24:5'd27]: cls = CLS_LEAD2;
            5'd28, 5'd29:  cls = CLS_LEAD3;
            5'd30:         cls = CLS_LEAD4;
            default:       cls = CLS_BAD;
        endcase
        return cls;
    endfunction

endpackage

// File: hdl/u8u16_front.sv
// u8u16_front: byte decoder; holds the open sequence and turns each byte
// into a command for the emitter. Depends on u8u16_pkg.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    input  logic       i_eos,
    output t_cmd       o_cmd,
    output logic       o_cmd_valid
);

    logic [1:0]  r_needed, n_needed;
    logic [1:0]  r_held,   n_held;
    logic [20:0] r_part,   n_part;

    logic [2:0]  cls;
    logic        fresh;
    logic [20:0] cont_part;
    logic [1:0]  cont_held;
    logic [1:0]  cont_needed;
    t_cmd        cmd;

    always_comb begin
        cls         = lead_class(i_byte[7:3]);
        n_needed    = r_needed;
        n_held      = r_held;
        n_part      = r_part;
        cmd         = '0;
        fresh       = 1'b1;
        cont_part   = {r_part[14:0], i_byte[5:0]};
        cont_held   = r_held + 2'd1;
        cont_needed = r_needed - 2'd1;

        if (r_needed != 2'd0) begin
            if (cls == CLS_CONT) begin
                fresh = 1'b0;
                if (cont_needed == 2'd0) begin
                    if (cont_part[20:16] == 5'd0) begin
                        cmd.tail  = 2'd1;
                        cmd.unit0 = cont_part[15:0];
                    end else begin
                        cmd.tail  = 2'd2;
                        cmd.unit0 = {5'd0, cont_part[20:10]} + HIGH_SURR_OFFSET;
                        cmd.unit1 = {LOW_SURR_TAG, cont_part[9:0]};
                    end
                    n_needed = 2'd0;
                    n_held   = 2'd0;
                    n_part   = '0;
                end else if (i_eos) begin
                    cmd.reps = cont_held;
                    n_needed = 2'd0;
                    n_held   = 2'd0;
                    n_part   = '0;
                end else begin
                    n_part   = cont_part;
                    n_held   = cont_held;
                    n_needed = cont_needed;
                end
            end else begin
                // broken sequence: flush what is held, then decode afresh
                cmd.reps = r_held;
                n_needed = 2'd0;
                n_held   = 2'd0;
                n_part   = '0;
            end
        end

        if (fresh) begin
            if (cls == CLS_ASCII) begin
                cmd.tail  = 2'd1;
                cmd.unit0 = {8'd0, i_byte};
            end else if (cls == CLS_CONT || cls == CLS_BAD || i_eos) begin
                cmd.tail  = 2'd1;
                cmd.unit0 = REPLACEMENT_UNIT;
            end else begin
                n_needed = 2'(cls - 3'd1);
                n_held   = 2'd1;
                case (cls)
                    CLS_LEAD2: n_part = {16'd0, i_byte[4:0]};
                    CLS_LEAD3: n_part = {17'd0, i_byte[3:0]};
                    default:   n_part = {18'd0, i_byte[2:0]};
                endcase
            end
        end
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = (cmd.reps != 2'd0) || (cmd.tail != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needed <= 2'd0;
            r_held   <= 2'd0;
            r_part   <= '0;
        end else if (i_take) begin
            r_needed <= n_needed;
            r_held   <= n_held;
            r_part   <= n_part;
        end
    end

    // sequence bookkeeping: nothing held when closed, never more than 4 bytes
    a_closed_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_needed == 2'd0) == (r_held == 2'd0))
        else $error("held count out of step with needed count");
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_held} + {1'b0, r_needed}) <= 3'd4)
        else $error("open sequence longer than four bytes");

endmodule

// File: hdl/u8u16_queue.sv
// u8u16_queue: small command FIFO between decoder and emitter.
// Depends on u8u16_pkg.
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_cmd,
    input  logic i_rd,
    output t_cmd o_head,
    output logic o_head_valid,
    output logic o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_wr && !i_rd) begin
            n_count = r_count + 1'b1;
        end else if (!i_wr && i_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (r_count == CNT_W'(DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (!o_full || i_rd))
        else $error("write into a full command queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> o_head_valid)
        else $error("read from an empty command queue");

endmodule

// File: hdl/u8u16_back.sv
// u8u16_back: emitter; walks the head command one unit per cycle into the
// output register while that register is empty or being popped. Depends on u8u16_pkg.
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_head,
    input  logic        i_head_valid,
    output logic        o_deq,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [15:0] o_code_unit,
    output logic        o_run_last
);

    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_last;
    logic [1:0]  r_idx;

    logic        load;
    logic [2:0]  total;
    logic        last;
    logic [15:0] unit;

    always_comb begin
        total = {1'b0, i_head.reps} + {1'b0, i_head.tail};
        last  = ({1'b0, r_idx} + 3'd1) == total;
        if (r_idx < i_head.reps) begin
            unit = REPLACEMENT_UNIT;
        end else if (r_idx == i_head.reps) begin
            unit = i_head.unit0;
        end else begin
            unit = i_head.unit1;
        end
        load = i_head_valid && (!r_valid || i_pop);
    end

    assign o_deq = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit <= unit;
            r_last <= last;
        end
    end

    assign o_empty     = !r_valid;
    assign o_code_unit = r_unit;
    assign o_run_last  = r_last;

    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_idx} < total))
        else $error("unit index ran past the head command");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_unit) && $stable(r_idx)))
        else $error("output unit or index moved while stalled");

endmodule

// File: hdl/utf8_to_utf16_transcoder.sv
// utf8_to_utf16_transcoder: top level; UTF-8 bytes in, UTF-16 code units out.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
// A byte's command enters the queue as the byte is taken; its first unit is loaded into the
// output register once that is empty or popped. Throughput: one byte per cycle while the
// queue has room; the emitter sends one unit per cycle while the consumer pops.
// Reset: synchronous, active low; drops any open sequence, queued commands and output unit.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    // code unit side
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_code_unit,
    output logic        o_run_last
);

    logic take;
    t_cmd cmd;
    logic cmd_valid;
    t_cmd head;
    logic head_valid;
    logic deq;
    logic q_full;

    // A byte is taken whenever the queue has room; bytes that only extend a
    // sequence produce no command and so never occupy a slot.
    assign take = push && !q_full;
    assign full = q_full;

    // Front: classifies the byte, tracks the open sequence and forms the
    // command (replacement count plus 0..2 trailing units).
    u8u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_in_byte),
        .i_eos       (i_end_of_string),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid)
    );

    // Queue: lets the decoder keep going while the emitter works through a
    // multi-unit command or the consumer stalls.
    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (take && cmd_valid),
        .i_wr_cmd     (cmd),
        .i_rd         (deq),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (q_full)
    );

    // Back: expands the head command one unit per cycle while the output register is free
    // or popped; the output register refills in the same cycle that the consumer pops.
    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_deq        (deq),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_code_unit  (o_code_unit),
        .o_run_last   (o_run_last)
    );

    // Only a completed command leaves the queue, and only when its final
    // unit goes into the output register flagged as last.
    a_deq_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        deq |=> (!empty && o_run_last))
        else $error("command retired without a last unit on the output");

endmodule

// File: dv/utf8_to_utf16_checker.sv
// utf8_to_utf16_checker: watches both queue sides of the transcoder, predicts the
// UTF-16 units each accepted byte should give and compares them in order.
// Depends on u8u16_pkg for the byte class codes and the replacement unit.
module utf8_to_utf16_checker
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_string,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] o_code_unit,
    input  logic        o_run_last,
    output int          o_fail_count,
    output int          o_units_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] HIGH_BASE = 16'hD800;
    localparam logic [15:0] LOW_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [15:0] unit_val;
        logic        is_last;
    } t_unit;

    t_unit       expected_units[$];
    // open sequence: continuation bytes still owed, bytes held, code point so far
    logic [1:0]  seq_left;
    logic [1:0]  seq_held;
    logic [20:0] seq_bits;

    function automatic logic [2:0] classify(input logic [7:0] b);
        if (!b[7]) return CLS_ASCII;
        if (!b[6]) return CLS_CONT;
        if (!b[5]) return CLS_LEAD2;
        if (!b[4]) return CLS_LEAD3;
        if (!b[3]) return CLS_LEAD4;
        return CLS_BAD;
    endfunction

    function automatic void transcode_byte(input logic [7:0] b, input logic eos);
        logic [15:0] units[$];
        logic [2:0]  cls;
        logic [20:0] v;
        bit          fresh;
        cls   = classify(b);
        fresh = 1'b1;
        if (seq_left != 2'd0) begin
            if (cls == CLS_CONT) begin
                fresh    = 1'b0;
                seq_bits = {seq_bits[14:0], b[5:0]};
                seq_held = seq_held + 2'd1;
                seq_left = seq_left - 2'd1;
                if (seq_left == 2'd0) begin
                    if (seq_bits < SUPP_BASE) begin
                        units.push_back(seq_bits[15:0]);
                    end else begin
                        v = seq_bits - SUPP_BASE;
                        units.push_back(HIGH_BASE + {5'd0, v[20:10]});
                        units.push_back(LOW_BASE + {6'd0, v[9:0]});
                    end
                    seq_held = 2'd0;
                    seq_bits = '0;
                end else if (eos) begin
                    // cut off at the end: one '?' per byte of the open sequence
                    for (int k = 0; k < seq_held; k++) units.push_back(REPLACEMENT_UNIT);
                    seq_left = 2'd0;
                    seq_held = 2'd0;
                    seq_bits = '0;
                end
            end else begin
                // broken sequence: flush held bytes, then decode this byte afresh
                for (int k = 0; k < seq_held; k++) units.push_back(REPLACEMENT_UNIT);
                seq_left = 2'd0;
                seq_held = 2'd0;
                seq_bits = '0;
            end
        end
        if (fresh) begin
            if (cls == CLS_ASCII) begin
                units.push_back({8'd0, b});
            end else if (cls == CLS_CONT || cls == CLS_BAD || eos) begin
                units.push_back(REPLACEMENT_UNIT);
            end else begin
                seq_left = 2'(cls - 3'd1);
                seq_held = 2'd1;
                case (cls)
                    CLS_LEAD2: seq_bits = {16'd0, b[4:0]};
                    CLS_LEAD3: seq_bits = {17'd0, b[3:0]};
                    default:   seq_bits = {18'd0, b[2:0]};
                endcase
            end
        end
        foreach (units[i]) expected_units.push_back('{units[i], i == units.size() - 1});
    endfunction

    always @(posedge i_clk) begin
        t_unit exp_unit;
        if (!i_rst_n) begin
            seq_left = 2'd0;
            seq_held = 2'd0;
            seq_bits = '0;
            expected_units.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_units.size() == 0) begin
                    $error("code_unit: expected none, actual %04h", o_code_unit);
                    o_fail_count++;
                end else begin
                    exp_unit = expected_units.pop_front();
                    if (o_code_unit !== exp_unit.unit_val) begin
                        $error("code_unit: expected %04h, actual %04h",
                               exp_unit.unit_val, o_code_unit);
                        o_fail_count++;
                    end
                    if (o_run_last !== exp_unit.is_last) begin
                        $error("run_last: expected %0d, actual %0d",
                               exp_unit.is_last, o_run_last);
                        o_fail_count++;
                    end
                end
            end
            if (push && !full) transcode_byte(i_in_byte, i_end_of_string);
        end
        o_units_waiting = expected_units.size();
    end

endmodule

// File: dv/utf8_to_utf16_transcoder_test.sv
// utf8_to_utf16_transcoder_test: top of the transcoder testbench; drives UTF-8 bytes
// and pops UTF-16 units with random gaps, and gives the verdict.
// Depends on utf8_to_utf16_transcoder, utf8_to_utf16_checker and u8u16_pkg.
module utf8_to_utf16_transcoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 430;
    localparam int HOLD_CYCLES  = 200;

    // Directed bytes, eos in bit 8: ASCII extremes, stray continuation, bad leads,
    // complete 2/3/4-byte sequences, a broken 4-byte sequence holding three bytes,
    // a sequence cut off by end of string, a lone lead at end of string and the
    // largest 4-byte form (above the Unicode range, converted as computed).
    localparam logic [8:0] DIRECTED [25] = '{
        9'h000, 9'h17F, 9'h080, 9'h0F8, 9'h0FF,
        9'h0C3, 9'h0A9,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h0F0, 9'h09F, 9'h098, 9'h041,
        9'h0E2, 9'h182,
        9'h1C3,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h1BF
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  i_in_byte = '0;
    logic        i_end_of_string = 1'b0;
    logic        full;
    logic        empty;
    logic [15:0] o_code_unit;
    logic        o_run_last;

    int fail_count;
    int units_waiting;
    int bytes_sent;
    // calm: no idling on that side for a stretch
    bit send_calm;
    bit pop_calm;
    // asks the receiver for one long hold-off so the block backs up
    bit hold_req;

    utf8_to_utf16_transcoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_code_unit     (o_code_unit),
        .o_run_last      (o_run_last)
    );

    utf8_to_utf16_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_code_unit     (o_code_unit),
        .o_run_last      (o_run_last),
        .o_fail_count    (fail_count),
        .o_units_waiting (units_waiting)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Mostly back to back, some short gaps, the odd long one.
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte and wait for its transfer; junk on the data lines while idle.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        i_in_byte       <= b;
        i_end_of_string <= eos;
        push            <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            push            <= 1'b0;
            i_in_byte       <= 8'($urandom);
            i_end_of_string <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One character of random content: mostly well formed, some cut short and
    // followed by a random byte, some pure noise.
    task automatic send_random_char();
        logic [7:0] seq [4];
        int len;
        int kind;
        int n;
        len = $urandom_range(1, 4);
        case (len)
            1:       seq[0] = 8'($urandom_range(8'h00, 8'h7F));
            2:       seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
            3:       seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
            default: seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
        endcase
        for (int i = 1; i < 4; i++) seq[i] = {2'b10, 6'($urandom)};
        kind = $urandom_range(0, 99);
        if (kind < 75) n = len;
        else if (kind < 88) n = (len > 1) ? $urandom_range(1, len - 1) : 1;
        else n = 0;
        // end of string mostly on the last byte, now and then mid-sequence
        for (int i = 0; i < n; i++)
            send_byte(seq[i], (i == n - 1) ? ($urandom_range(0, 4) == 0)
                                           : ($urandom_range(0, 19) == 0));
        if (kind >= 75) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    endtask

    // Receiver: pops with random gaps; one long hold-off on request.
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                pop      <= 1'b0;
                hold_req  = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            if ($urandom_range(0, 39) == 0) pop_calm = !pop_calm;
            gap = pick_gap(pop_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

        // random part opens with the receiver held off and the sender flat out
        send_calm = 1'b1;
        hold_req  = 1'b1;
        while (bytes_sent < RANDOM_BYTES + $size(DIRECTED)) begin
            if ($urandom_range(0, 24) == 0) send_calm = ($urandom_range(0, 2) == 0);
            send_random_char();
        end
        push <= 1'b0;

        // drain, then leave room for any stray unit to show up
        @(posedge i_clk);
        while (units_waiting != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
